// ===== src/lwc_pkg.sv =====
// ---------------------------------------------------------------------------
// lwc_pkg
// shared types and constants for the lru write-back cache
// ---------------------------------------------------------------------------
package lwc_pkg;

  localparam int MaxWaysDef  = 8;
  localparam int MaxSetsDef  = 1024;
  localparam int AddrBitsDef = 30;

  localparam int FuncW  = 1;
  localparam int BlockW = 30;

  localparam logic [0:0] RegWaysLog2 = 1'b0;
  localparam logic [0:0] RegSetsLog2 = 1'b1;

  localparam logic MemOpFill      = 1'b0;
  localparam logic MemOpWriteback = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_OUT_WB,
    ST_OUT_FILL
  } lwc_state_e;

  typedef struct packed {
    logic clear_en;
    logic load_in;
    logic rd_set;
    logic commit;
    logic out_wb;
    logic out_fill;
  } lwc_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic hit;
    logic need_wb;
  } lwc_sts_t;

  function automatic int clamp_log(input int lg, input int limit);
    int w;
    w = lg;
    for (int k = 0; k < 16; k++) begin
      if (w > 0 && (1 << w) > limit) w = w - 1;
    end
    return w;
  endfunction

endpackage

// ===== src/lwc_ctrl.sv =====
// ---------------------------------------------------------------------------
// lwc_ctrl
// sequencer for clear, lookup, update and result transactions
// ---------------------------------------------------------------------------
module lwc_ctrl
  import lwc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  lwc_sts_t sts_i,
  output lwc_cmd_t cmd_o
);

  lwc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_set = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        // the write-back block is latched in the datapath on commit
        cmd_o.commit = 1'b1;
        if (sts_i.hit) state_d = ST_IDLE;
        else if (sts_i.need_wb) state_d = ST_OUT_WB;
        else state_d = ST_OUT_FILL;
      end
      ST_OUT_WB: begin
        out_valid_o  = 1'b1;
        cmd_o.out_wb = 1'b1;
        if (out_ready_i) state_d = ST_OUT_FILL;
      end
      ST_OUT_FILL: begin
        out_valid_o    = 1'b1;
        cmd_o.out_fill = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/lwc_datapath.sv =====
// ---------------------------------------------------------------------------
// lwc_datapath
// line store, lookup, lru ages and result formatting
// ---------------------------------------------------------------------------
module lwc_datapath
  import lwc_pkg::*;
#(
  parameter int MAX_WAYS  = MaxWaysDef,
  parameter int MAX_SETS  = MaxSetsDef,
  parameter int ADDR_BITS = AddrBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lwc_cmd_t          cmd_i,
  output lwc_sts_t          sts_o,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [3:0]        cfg_data_i,
  input  logic [FuncW-1:0]  func_i,
  input  logic [BlockW-1:0] block_i,
  output logic              mem_op_o,
  output logic [BlockW-1:0] mem_block_o,
  output logic              last_o
);

  localparam int SetW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WayW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AgeW  = WayW;
  localparam int AW    = (ADDR_BITS < BlockW) ? ADDR_BITS : BlockW;
  localparam int MaxWl = clamp_log(3, MAX_WAYS);
  localparam int MaxSl = clamp_log(15, MAX_SETS);
  // one row holds all ways: valid, dirty, age, block
  localparam int EntW  = 2 + AgeW + AW;
  localparam int RowW  = MAX_WAYS * EntW;

  logic [1:0] ways_log2_q;
  logic [3:0] sets_log2_q;
  logic [1:0] wl;
  logic [3:0] sl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_log2_q <= 2'd2;
      sets_log2_q <= 4'd3;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegWaysLog2) ways_log2_q <= cfg_data_i[1:0];
      else sets_log2_q <= cfg_data_i;
    end
  end

  always_comb begin
    wl = ways_log2_q;
    if (int'(wl) > MaxWl) wl = 2'(MaxWl);
    sl = sets_log2_q;
    if (int'(sl) > MaxSl) sl = 4'(MaxSl);
  end

  logic [RowW-1:0] mem [MAX_SETS];
  logic [RowW-1:0] row_q;
  logic [SetW:0]   clr_q;
  logic            wr_q;
  logic [AW-1:0]   blk_q;
  logic [SetW-1:0] set_q;
  logic [WayW:0]   ways_q;

  logic [WayW:0]   nways;
  logic [AW-1:0]   blk_in;
  logic [SetW-1:0] set_in;

  always_comb begin
    nways  = (WayW+1)'(1) << wl;
    blk_in = block_i[AW-1:0];
    set_in = SetW'((blk_in >> wl) & AW'((64'd1 << sl) - 64'd1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_en && !clr_q[SetW]) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      wr_q   <= func_i[0];
      blk_q  <= blk_in;
      set_q  <= set_in;
      ways_q <= nways;
    end
  end

  // decision logic over the registered row
  logic [MAX_WAYS-1:0] v, d, act, hitv, freev;
  logic [AgeW-1:0]     age [MAX_WAYS];
  logic [AW-1:0]       bk  [MAX_WAYS];
  logic                hit, has_free;
  logic [WayW-1:0]     way, hway, fway, vway;
  logic [AgeW-1:0]     rank, vage;
  logic [RowW-1:0]     new_row;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      v[i]   = row_q[i*EntW + AW + AgeW + 1];
      d[i]   = row_q[i*EntW + AW + AgeW];
      age[i] = row_q[i*EntW + AW +: AgeW];
      bk[i]  = row_q[i*EntW +: AW];
      act[i] = (i < int'(ways_q));
      hitv[i]  = act[i] && v[i] && (bk[i] == blk_q);
      freev[i] = act[i] && !v[i];
    end
    hit = |hitv;
    has_free = |freev;
    hway = '0;
    fway = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hitv[i]) hway = WayW'(i);
      if (freev[i]) fway = WayW'(i);
    end
    vway = '0;
    vage = age[0];
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (act[i] && age[i] > vage) begin
        vway = WayW'(i);
        vage = age[i];
      end
    end
    if (hit) begin
      way  = hway;
      rank = age[hway];
    end else begin
      way  = has_free ? fway : vway;
      rank = '1;
    end
    new_row = row_q;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (act[i] && WayW'(i) != way && v[i] && (hit ? age[i] < rank : 1'b1)
          && ({1'b0, age[i]} < (ways_q - 1'b1))) begin
        new_row[i*EntW + AW +: AgeW] = age[i] + 1'b1;
      end
    end
    new_row[int'(way)*EntW + AW +: AgeW] = '0;
    if (hit) begin
      if (wr_q) new_row[int'(way)*EntW + AW + AgeW] = 1'b1;
    end else begin
      new_row[int'(way)*EntW +: AW]             = blk_q;
      new_row[int'(way)*EntW + AW + AgeW]       = wr_q;
      new_row[int'(way)*EntW + AW + AgeW + 1]   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_en && !clr_q[SetW]) begin
      mem[clr_q[SetW-1:0]] <= '0;
    end else if (cmd_i.commit) begin
      mem[set_q] <= new_row;
    end
    if (cmd_i.rd_set) row_q <= mem[set_q];
  end

  logic [AW-1:0] wb_blk_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      wb_blk_q <= bk[vway];
    end
  end

  assign sts_o.clear_done = clr_q[SetW];
  assign sts_o.hit        = hit;
  assign sts_o.need_wb    = !hit && !has_free && d[vway];

  assign mem_op_o    = cmd_i.out_wb ? MemOpWriteback : MemOpFill;
  assign mem_block_o = BlockW'(cmd_i.out_wb ? wb_blk_q : blk_q);
  assign last_o      = cmd_i.out_fill;

endmodule

// ===== src/lru_writeback_cache_model.sv =====
// ---------------------------------------------------------------------------
// lru_writeback_cache_model
// set-associative lru cache, write-back and write-allocate, streaming top
// ---------------------------------------------------------------------------
// sequencing: an access is accepted in ST_IDLE, its row is read in ST_READ and
//   updated in ST_DECIDE; a miss then issues its memory transactions
// one access at a time: the next is taken only back in ST_IDLE, plus output stalls,
//   set by the single-port row memory read-modify-write in the sequencer
// reset: a clearing pass zeroes valid, dirty and age of every row;
//   no input transaction is taken meanwhile
module lru_writeback_cache_model
  import lwc_pkg::*;
#(
  parameter int MAX_WAYS  = MaxWaysDef,
  parameter int MAX_SETS  = MaxSetsDef,
  parameter int ADDR_BITS = AddrBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  // access stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // func [0], block_addr [30:1], zero pad
  // memory transaction stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // mem_op [0], mem_block [30:1], zero pad
  output logic        m_axis_tlast
);

  lwc_cmd_t cmd;
  lwc_sts_t sts;
  logic              mem_op;
  logic [BlockW-1:0] mem_block;

  // sequencer
  lwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // line store and lookup
  lwc_datapath #(
    .MAX_WAYS  (MAX_WAYS),
    .MAX_SETS  (MAX_SETS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .func_i      (s_axis_tdata[0:0]),
    .block_i     (s_axis_tdata[30:1]),
    .mem_op_o    (mem_op),
    .mem_block_o (mem_block),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, mem_block, mem_op};

endmodule

// ===== tb/lru_writeback_cache_model_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lru_writeback_cache_model_tb
// drives random and directed cache accesses and checks every memory
// transaction against a behavioural lru write-back cache held in the bench
// ---------------------------------------------------------------------------
module lru_writeback_cache_model_tb
  import lwc_pkg::*;
;

  localparam int NWays   = MaxWaysDef;
  localparam int NSets   = MaxSetsDef;
  localparam int NLines  = NWays * NSets;
  localparam int CycLimit = 400000;

  typedef struct packed {
    logic              func;
    logic [BlockW-1:0] blk;
  } access_t;

  typedef struct packed {
    logic              op;
    logic [BlockW-1:0] blk;
    logic              last;
  } memtxn_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = '0;
  logic [3:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  lru_writeback_cache_model dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // bench copy of cache state and registers
  logic [BlockW-1:0] tag_mem [NLines];
  logic              vld_mem [NLines];
  logic              drt_mem [NLines];
  int unsigned       age_mem [NLines];
  logic [1:0]        ways_reg;
  logic [3:0]        sets_reg;

  access_t access_q[$];     // accesses waiting for the driver
  memtxn_t exp_txn_q[$];    // memory transactions still to come
  int      mismatches = 0;
  int      txn_seen = 0;
  int      wb_seen = 0;
  int      hits = 0;
  longint  cycles = 0;
  bit      hold_src = 1'b0;

  function automatic int clamp_lg(input int lg, input int lim);
    int w;
    w = lg;
    while (w > 0 && (1 << w) > lim) w--;
    return w;
  endfunction

  // promote one way to most recent, younger lines age by one
  function automatic void promote(input int base, input int ways, input int hw,
                                  input int unsigned rank);
    for (int i = 0; i < ways; i++) begin
      if (i != hw && vld_mem[base+i] && age_mem[base+i] < rank &&
          age_mem[base+i] < ways - 1)
        age_mem[base+i]++;
    end
    age_mem[base+hw] = 0;
  endfunction

  // predict memory transactions caused by one access
  function automatic void predict_access(input access_t a);
    int wl, sl, ways, set, base, way;
    memtxn_t t;
    wl = clamp_lg(ways_reg, NWays);
    sl = clamp_lg(sets_reg, NSets);
    ways = 1 << wl;
    set = (a.blk >> wl) & ((1 << sl) - 1);
    base = set * NWays;
    way = ways;
    for (int i = 0; i < ways; i++)
      if (way == ways && vld_mem[base+i] && tag_mem[base+i] == a.blk) way = i;
    if (way < ways) begin
      promote(base, ways, way, age_mem[base+way]);
      if (a.func) drt_mem[base+way] = 1'b1;
      hits++;
      return;
    end
    for (int i = 0; i < ways; i++)
      if (way == ways && !vld_mem[base+i]) way = i;
    if (way == ways) begin
      way = 0;
      for (int i = 1; i < ways; i++)
        if (age_mem[base+i] > age_mem[base+way]) way = i;
      if (drt_mem[base+way]) begin
        t.op = MemOpWriteback; t.blk = tag_mem[base+way]; t.last = 1'b0;
        exp_txn_q.push_back(t);
      end
    end
    promote(base, ways, way, ways);
    tag_mem[base+way] = a.blk;
    vld_mem[base+way] = 1'b1;
    drt_mem[base+way] = a.func;
    t.op = MemOpFill; t.blk = a.blk; t.last = 1'b1;
    exp_txn_q.push_back(t);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // access handshake seen at the last rising edge
  logic in_hs = 1'b0;
  always @(posedge clk_i) begin
    in_hs <= s_axis_tvalid && s_axis_tready;
  end

  // driver: presents accesses, one transaction per handshake
  int src_gap = 0;
  always @(negedge clk_i) begin
    access_t a;
    if (s_axis_tvalid && !in_hs) begin
      // hold current access
    end else if (src_gap > 0) begin
      src_gap <= src_gap - 1;
      s_axis_tvalid <= 1'b0;
    end else if (access_q.size() > 0 && !hold_src) begin
      a = access_q.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {1'b0, a.blk, a.func};
      src_gap <= gap_len();
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // sink back-pressure
  int snk_gap = 0;
  always @(negedge clk_i) begin
    if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      snk_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
    end
  end

  // monitor: predict on accepted access, check each memory transaction
  always @(posedge clk_i) begin
    memtxn_t got, want;
    access_t acc;
    cycles <= cycles + 1;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      acc.func = s_axis_tdata[0];
      acc.blk  = s_axis_tdata[30:1];
      predict_access(acc);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.op = m_axis_tdata[0]; got.blk = m_axis_tdata[30:1]; got.last = m_axis_tlast;
      txn_seen++;
      if (got.op == MemOpWriteback) wb_seen++;
      if (exp_txn_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction op=%0d blk=%h last=%0d",
                                       got.op, got.blk, got.last);
      end else begin
        want = exp_txn_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp op=%0d blk=%h last=%0d, got op=%0d blk=%h last=%0d",
                     want.op, want.blk, want.last, got.op, got.blk, got.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycles > CycLimit) begin
      $display("lru_writeback_cache_model verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegWaysLog2) ways_reg = val[1:0];
    else sets_reg = val;
  endtask

  // wait for the block to drain before touching registers
  task automatic drain();
    while (access_q.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
    while (s_axis_tvalid || exp_txn_q.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic push(input logic f, input logic [BlockW-1:0] b);
    access_t a;
    a.func = f; a.blk = b;
    access_q.push_back(a);
  endtask

  // random phase mostly reuses a small pool so hits and evictions happen
  task automatic random_phase(input int n);
    logic [BlockW-1:0] pool[16];
    for (int i = 0; i < 16; i++) pool[i] = BlockW'($urandom_range(0, 255));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8)
        push(1'($urandom_range(0, 1)), pool[$urandom_range(0, 15)]);
      else
        push(1'($urandom_range(0, 1)), BlockW'($urandom()));
    end
  endtask

  initial begin
    ways_reg = 2'd2;
    sets_reg = 4'd3;
    for (int i = 0; i < NLines; i++) begin
      vld_mem[i] = 1'b0; drt_mem[i] = 1'b0; age_mem[i] = 0; tag_mem[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: one set, fill, dirty eviction, extremes of the block field
    push(1'b1, 30'h0); push(1'b0, 30'h4 << 3); push(1'b1, 30'h8 << 3);
    push(1'b0, 30'hc << 3); push(1'b0, 30'h0); push(1'b0, 30'h10 << 3);
    push(1'b1, 30'h14 << 3); push(1'b0, 30'h0);
    push(1'b1, 30'h3fff_ffff); push(1'b0, 30'h2aaa_aaaa); push(1'b1, 30'h1555_5555);
    push(1'b0, 30'h3fff_ffff);
    drain();

    // tiny cache: direct mapped single set
    write_reg(RegWaysLog2, 4'd0); write_reg(RegSetsLog2, 4'd0);
    push(1'b1, 30'd5); push(1'b1, 30'd6); push(1'b0, 30'd6); push(1'b0, 30'd5);
    random_phase(80);
    drain();

    // largest: 8 ways, oversize set register clamped
    write_reg(RegWaysLog2, 4'd3); write_reg(RegSetsLog2, 4'd15);
    random_phase(200);
    drain();

    // hold-off until idle, then continue
    hold_src = 1'b1;
    write_reg(RegWaysLog2, 4'd1); write_reg(RegSetsLog2, 4'd2);
    random_phase(150);
    repeat (5) @(negedge clk_i);
    hold_src = 1'b0;
    repeat (200) @(negedge clk_i);
    hold_src = 1'b1;
    while (s_axis_tvalid || exp_txn_q.size() != 0) @(negedge clk_i);
    hold_src = 1'b0;
    drain();

    // contents kept across a change of ways
    write_reg(RegWaysLog2, 4'd2); write_reg(RegSetsLog2, 4'd10);
    random_phase(150);
    drain();
    write_reg(RegWaysLog2, 4'd3); write_reg(RegSetsLog2, 4'd1);
    random_phase(150);
    drain();

    $display("ran %0d memory transactions (%0d write-backs), %0d hits, over six settings",
             txn_seen, wb_seen, hits);
    if (mismatches == 0 && exp_txn_q.size() == 0) begin
      $display("lru_writeback_cache_model verification clean");
    end else begin
      $display("lru_writeback_cache_model verification failed");
    end
    $finish;
  end

endmodule
